// File: sv/stiffly_stable_step_update_unit_assert.svh
// ----------------------------------------------------------------------------
// stiffly stable step update assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef STIFFLY_STABLE_STEP_UPDATE_UNIT_ASSERT_SVH
`define STIFFLY_STABLE_STEP_UPDATE_UNIT_ASSERT_SVH

// antecedent in a cycle implies consequent in the same cycle
`define SSU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds at a clock edge
`define SSU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// File: sv/ssu_pkg.sv
// ----------------------------------------------------------------------------
// ssu_pkg
// shared types, constants and helper functions of the step update unit
// ----------------------------------------------------------------------------
package ssu_pkg;

  localparam int ELEMENTS_DEFAULT = 4096;
  localparam int INDEX_W          = 12;
  localparam int VALUE_W          = 32;
  localparam int DT_W             = 31;
  localparam int STEP_W           = 48;
  localparam int WIDE_W           = 49;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [DT_W-1:0] DT_RESET = 31'd65536;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // rounding divide by 11 done as floor((2n + 11) / 22) on an offset numerator
  localparam int DIV_STAGES = 5;
  localparam int DIV_DIGITS = 8;
  localparam int DIV_W      = DIV_STAGES * DIV_DIGITS;
  localparam int REM_W      = 5;
  localparam logic [REM_W-1:0] DIVISOR = 5'd22;
  localparam logic signed [57:0] DIV_OFFSET = 58'sd47244640256;  // 22 * 2^31

  // one history entry as kept in the history ram
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] pv1;
    logic signed [VALUE_W-1:0] pv2;
    logic signed [VALUE_W-1:0] pr1;
    logic signed [VALUE_W-1:0] pr2;
  } hist_t;

  // classified word handed from the front to the back
  typedef struct packed {
    logic [INDEX_W-1:0]        idx;
    logic signed [VALUE_W-1:0] f0;
    logic signed [VALUE_W-1:0] s0;
    logic signed [VALUE_W-1:0] d0;
    logic signed [VALUE_W-1:0] fm1;
    logic signed [VALUE_W-1:0] fm2;
    logic signed [VALUE_W-1:0] sm1;
    logic signed [VALUE_W-1:0] sm2;
    logic                      fill;
    logic signed [STEP_W-1:0]  step;
  } mid_t;

  // finished result word
  typedef struct packed {
    logic [INDEX_W-1:0]        idx;
    logic signed [VALUE_W-1:0] value;
    logic                      sat;
  } out_t;

  function automatic logic signed [VALUE_W-1:0] sat_value(
    input logic signed [WIDE_W-1:0] v
  );
    if (v > WIDE_W'(VALUE_MAX)) begin
      return VALUE_MAX;
    end else if (v < WIDE_W'(VALUE_MIN)) begin
      return VALUE_MIN;
    end else begin
      return $signed(v[VALUE_W-1:0]);
    end
  endfunction

  // restoring division by DIVISOR over one group of numerator bits
  function automatic logic [REM_W+DIV_DIGITS-1:0] div_digits(
    input logic [REM_W-1:0]      rem_in,
    input logic [DIV_DIGITS-1:0] num
  );
    logic [REM_W:0]          part;
    logic [REM_W-1:0]        rem;
    logic [DIV_DIGITS-1:0]   q;
    rem = rem_in;
    q   = '0;
    for (int i = DIV_DIGITS - 1; i >= 0; i--) begin
      part = {rem, num[i]};
      if (part >= {1'b0, DIVISOR}) begin
        part = part - {1'b0, DIVISOR};
        q[i] = 1'b1;
      end
      rem = part[REM_W-1:0];
    end
    return {rem, q};
  endfunction

endpackage

// File: sv/ssu_ram.sv
// ----------------------------------------------------------------------------
// ssu_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ssu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/ssu_fifo.sv
// ----------------------------------------------------------------------------
// ssu_fifo
// small register queue; a push is taken while full if a pop happens too
// ----------------------------------------------------------------------------
`include "stiffly_stable_step_update_unit_assert.svh"

module ssu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] rptr;
  logic [PTR_W-1:0] wptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= '0;
      wptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SSU_ASSERT_NEVER(fifo_no_overflow, push && full && !pop, "queue written while full")
  `SSU_ASSERT_NEVER(fifo_no_underflow, pop && empty, "queue read while empty")

endmodule

// File: sv/ssu_front.sv
// ----------------------------------------------------------------------------
// ssu_front
// takes items, reads element history, classifies fill or reuse, writes back
// ----------------------------------------------------------------------------
`include "stiffly_stable_step_update_unit_assert.svh"

module ssu_front #(
  parameter int ELEMENTS = ssu_pkg::ELEMENTS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [ssu_pkg::DT_W-1:0]             dt,
  input  logic                                 push,
  input  logic [ssu_pkg::INDEX_W-1:0]          element_index,
  input  logic signed [ssu_pkg::VALUE_W-1:0]   current_value,
  input  logic signed [ssu_pkg::VALUE_W-1:0]   convective_rate,
  input  logic signed [ssu_pkg::VALUE_W-1:0]   diffusive_rate,
  input  logic                                 restart,
  output logic                                 full,
  output logic                                 mid_push,
  output ssu_pkg::mid_t                        mid_data,
  input  logic                                 mid_full
);

  localparam int ADDR_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int HIST_W = $bits(ssu_pkg::hist_t);

  // clearing pass over the valid bits after reset
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // stage b: item waiting on its history read
  logic                                b_valid;
  logic [ssu_pkg::INDEX_W-1:0]         b_idx;
  logic [ADDR_W-1:0]                   b_addr;
  logic signed [ssu_pkg::VALUE_W-1:0]  b_f0;
  logic signed [ssu_pkg::VALUE_W-1:0]  b_s0;
  logic signed [ssu_pkg::VALUE_W-1:0]  b_d0;
  logic                                b_restart;
  logic                                b_in_range;
  logic                                b_fwd;
  logic signed [ssu_pkg::STEP_W-1:0]   b_step;
  logic                                b_go;

  // last history written, for a read that raced its write
  ssu_pkg::hist_t              last_wr;
  logic [ssu_pkg::INDEX_W-1:0] last_idx;

  logic                                accept;
  logic                                in_range;
  logic                                fwd_hit;
  logic signed [63:0]                  step_prod;
  logic signed [63:0]                  step_rnd;
  logic [HIST_W-1:0]                   ram_rdata;
  logic [HIST_W-1:0]                   ram_wdata;
  logic [ADDR_W-1:0]                   ram_waddr;
  logic                                ram_we;
  logic                                hist_wr;
  ssu_pkg::hist_t                      hist;
  ssu_pkg::hist_t                      new_hist;
  logic                                fill;
  logic signed [ssu_pkg::VALUE_W-1:0]  fm1_fill;

  assign full     = rst | clearing | (b_valid & mid_full);
  assign accept   = push & ~full;
  assign b_go     = b_valid & ~mid_full;
  assign hist_wr  = b_go & b_in_range;
  assign in_range = (32'(element_index) < ELEMENTS);
  assign fwd_hit  = hist_wr & (b_idx == element_index);

  // rounded dt * S0, reused for both fill values
  assign step_prod = convective_rate * $signed({1'b0, dt});
  assign step_rnd  = step_prod + 64'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(ELEMENTS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_idx      <= element_index;
      b_addr     <= ADDR_W'(element_index);
      b_f0       <= current_value;
      b_s0       <= convective_rate;
      b_d0       <= diffusive_rate;
      b_restart  <= restart;
      b_in_range <= in_range;
      b_fwd      <= fwd_hit;
      b_step     <= step_rnd[63:16];
    end
    if (hist_wr) begin
      last_wr  <= new_hist;
      last_idx <= b_idx;
    end
  end

  ssu_ram #(
    .WIDTH (HIST_W),
    .DEPTH (ELEMENTS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ADDR_W'(element_index)),
    .rdata (ram_rdata)
  );

  always_comb begin
    hist     = b_fwd ? last_wr : ssu_pkg::hist_t'(ram_rdata);
    fill     = b_restart | ~b_in_range | ~hist.valid;
    fm1_fill = ssu_pkg::sat_value(ssu_pkg::WIDE_W'(b_f0) - ssu_pkg::WIDE_W'(b_step));

    mid_data.idx  = b_idx;
    mid_data.f0   = b_f0;
    mid_data.s0   = b_s0;
    mid_data.d0   = b_d0;
    mid_data.fm1  = fill ? fm1_fill : hist.pv1;
    mid_data.fm2  = hist.pv2;  // replaced in the back when filling
    mid_data.sm1  = fill ? b_s0 : hist.pr1;
    mid_data.sm2  = fill ? b_s0 : hist.pr2;
    mid_data.fill = fill;
    mid_data.step = b_step;

    // history shifts by one step
    new_hist.valid = 1'b1;
    new_hist.pv1   = b_f0;
    new_hist.pv2   = mid_data.fm1;
    new_hist.pr1   = b_s0;
    new_hist.pr2   = mid_data.sm1;
  end

  assign mid_push  = b_go;
  assign ram_we    = clearing | hist_wr;
  assign ram_waddr = clearing ? clr_addr : b_addr;
  assign ram_wdata = clearing ? '0 : new_hist;

  `SSU_ASSERT_IMPLY(fwd_matches_write, b_valid && b_fwd, b_in_range && (last_idx == b_idx), "forwarded history belongs to another element")
  `SSU_ASSERT_IMPLY(no_item_while_clearing, clearing, !b_valid, "item in flight during clearing pass")

endmodule

// File: sv/ssu_back.sv
// ----------------------------------------------------------------------------
// ssu_back
// arithmetic pipeline: rate sum, dt product, weighted sum, divide by eleven
// ----------------------------------------------------------------------------
module ssu_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ssu_pkg::DT_W-1:0] dt,
  input  logic                     mid_empty,
  output logic                     mid_pop,
  input  ssu_pkg::mid_t            mid_data,
  input  logic                     out_full,
  input  logic                     out_pop,
  output logic                     out_push,
  output ssu_pkg::out_t            out_data
);

  localparam int NS = ssu_pkg::DIV_STAGES;
  localparam int DW = ssu_pkg::DIV_W;
  localparam int DD = ssu_pkg::DIV_DIGITS;
  localparam int RW = ssu_pkg::REM_W;
  localparam int VW = ssu_pkg::VALUE_W;
  localparam int IW = ssu_pkg::INDEX_W;

  logic en;

  // stage 1: fill fm2, rate sum
  logic                   v1;
  logic [IW-1:0]          s1_idx;
  logic signed [VW-1:0]   s1_f0;
  logic signed [VW-1:0]   s1_fm1;
  logic signed [VW-1:0]   s1_fm2;
  logic signed [35:0]     s1_r;
  logic signed [VW-1:0]   fm2_fill;
  logic signed [35:0]     r_c;

  // stage 2: partial products of dt * r, weighted value sum
  logic                   v2;
  logic [IW-1:0]          s2_idx;
  logic signed [37:0]     s2_a;
  logic [48:0]            s2_plo;
  logic signed [49:0]     s2_phi;
  logic signed [37:0]     a_c;

  // stage 3: rounded product
  logic                   v3;
  logic [IW-1:0]          s3_idx;
  logic signed [37:0]     s3_a;
  logic signed [51:0]     s3_p;
  logic signed [67:0]     prod_c;

  // stage 4: numerator
  logic                   v4;
  logic [IW-1:0]          s4_idx;
  logic signed [56:0]     s4_n;

  // stage 5: saturation test and offset numerator
  logic                   v5;
  logic [IW-1:0]          s5_idx;
  logic                   s5_hi;
  logic                   s5_lo;
  logic [DW-1:0]          s5_u;
  logic signed [57:0]     m_c;
  logic signed [57:0]     u_c;

  // division stages
  logic                   dv   [NS];
  logic [IW-1:0]          didx [NS];
  logic                   dhi  [NS];
  logic                   dlo  [NS];
  logic [RW-1:0]          drem [NS];
  logic [DW-1:0]          dnum [NS];
  logic [VW-1:0]          dq   [NS];

  logic                   in_v   [NS];
  logic [IW-1:0]          in_idx [NS];
  logic                   in_hi  [NS];
  logic                   in_lo  [NS];
  logic [RW-1:0]          in_rem [NS];
  logic [DW-1:0]          in_num [NS];
  logic [VW-1:0]          in_q   [NS];
  logic [RW+DD-1:0]       step_out [NS];

  // the whole pipeline moves unless the finished word cannot leave
  assign en       = ~dv[NS-1] | ~out_full | out_pop;
  assign mid_pop  = en & ~mid_empty;
  assign out_push = dv[NS-1] & en;

  always_comb begin
    fm2_fill = ssu_pkg::sat_value(ssu_pkg::WIDE_W'(mid_data.fm1)
                                  - ssu_pkg::WIDE_W'(mid_data.step));
    r_c = (36'(mid_data.s0) <<< 1) + 36'(mid_data.s0)
        - ((36'(mid_data.sm1) <<< 1) + 36'(mid_data.sm1))
        + 36'(mid_data.sm2) + 36'(mid_data.d0);
    a_c = (38'(s1_f0) <<< 4) + (38'(s1_f0) <<< 1)
        - ((38'(s1_fm1) <<< 3) + 38'(s1_fm1))
        + (38'(s1_fm2) <<< 1);
    prod_c = (68'(s2_phi) <<< 18) + $signed({19'b0, s2_plo}) + 68'sd32768;
    m_c = (58'(s4_n) <<< 1) + 58'sd11;
    u_c = m_c + ssu_pkg::DIV_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= mid_pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx <= mid_data.idx;
      s1_f0  <= mid_data.f0;
      s1_fm1 <= mid_data.fm1;
      s1_fm2 <= mid_data.fill ? fm2_fill : mid_data.fm2;
      s1_r   <= r_c;

      s2_idx <= s1_idx;
      s2_a   <= a_c;
      s2_plo <= 49'(dt) * 49'(s1_r[17:0]);
      s2_phi <= $signed(s1_r[35:18]) * $signed({1'b0, dt});

      s3_idx <= s2_idx;
      s3_a   <= s2_a;
      s3_p   <= prod_c[67:16];

      s4_idx <= s3_idx;
      s4_n   <= 57'(s3_a) + (57'(s3_p) <<< 2) + (57'(s3_p) <<< 1);

      s5_idx <= s4_idx;
      s5_hi  <= (m_c >= ssu_pkg::DIV_OFFSET);
      s5_lo  <= (m_c < -ssu_pkg::DIV_OFFSET);
      s5_u   <= u_c[DW-1:0];
    end
  end

  always_comb begin
    in_v[0]   = v5;
    in_idx[0] = s5_idx;
    in_hi[0]  = s5_hi;
    in_lo[0]  = s5_lo;
    in_rem[0] = '0;
    in_num[0] = s5_u;
    in_q[0]   = '0;
    for (int k = 1; k < NS; k++) begin
      in_v[k]   = dv[k-1];
      in_idx[k] = didx[k-1];
      in_hi[k]  = dhi[k-1];
      in_lo[k]  = dlo[k-1];
      in_rem[k] = drem[k-1];
      in_num[k] = dnum[k-1];
      in_q[k]   = dq[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      step_out[k] = ssu_pkg::div_digits(in_rem[k], in_num[k][DW-1 -: DD]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        dv[k] <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < NS; k++) begin
        dv[k] <= in_v[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        didx[k] <= in_idx[k];
        dhi[k]  <= in_hi[k];
        dlo[k]  <= in_lo[k];
        drem[k] <= step_out[k][RW+DD-1:DD];
        dnum[k] <= in_num[k] << DD;
        dq[k]   <= {in_q[k][VW-DD-1:0], step_out[k][DD-1:0]};
      end
    end
  end

  // quotient carries an offset of 2^31: flipping the top bit removes it
  always_comb begin
    out_data.idx = didx[NS-1];
    out_data.sat = dhi[NS-1] | dlo[NS-1];
    if (dhi[NS-1]) begin
      out_data.value = ssu_pkg::VALUE_MAX;
    end else if (dlo[NS-1]) begin
      out_data.value = ssu_pkg::VALUE_MIN;
    end else begin
      out_data.value = $signed({~dq[NS-1][VW-1], dq[NS-1][VW-2:0]});
    end
  end

endmodule

// File: sv/stiffly_stable_step_update_unit.sv
// ----------------------------------------------------------------------------
// stiffly_stable_step_update_unit
// third order stiffly stable substep for a stream of state elements
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: drive push with one word (element index, value,
//   convective rate, diffusive rate, restart); the word is taken on a clock
//   edge with push high and full low. one word can be taken every cycle while
//   full stays low, including back to back words for the same element.
//   result side is a queue: while empty is low the oldest result (index,
//   next value, saturated flag) sits on the ports; pop takes it.
//   time_step_we writes time_step_wdata into the substep register (reset 1.0
//   in unsigned q15.16); write it only while no word is in flight.
// path and rate
//   a taken word passes stage b of the history front, the middle queue, the
//   arithmetic and division stages of the back and the output queue. rate is
//   one word per cycle when nothing stalls, set by the single read and write
//   port of the history ram and the fully pipelined back end.
// reset
//   rst clears the queues and starts a sweep of the history valid bits, one
//   element per cycle; full stays high until all ELEMENTS (4096 by default) are done.
// stall
//   if pop is held low, results collect in the output queue, the back end
//   then freezes, the middle queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module stiffly_stable_step_update_unit #(
  parameter int ELEMENTS = ssu_pkg::ELEMENTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                time_step_we,
  input  logic [ssu_pkg::DT_W-1:0]            time_step_wdata,
  // input queue side
  input  logic                                push,
  output logic                                full,
  input  logic [ssu_pkg::INDEX_W-1:0]         element_index,
  input  logic signed [ssu_pkg::VALUE_W-1:0]  current_value,
  input  logic signed [ssu_pkg::VALUE_W-1:0]  convective_rate,
  input  logic signed [ssu_pkg::VALUE_W-1:0]  diffusive_rate,
  input  logic                                restart,
  // result queue side
  output logic                                empty,
  input  logic                                pop,
  output logic [ssu_pkg::INDEX_W-1:0]         result_index,
  output logic signed [ssu_pkg::VALUE_W-1:0]  next_value,
  output logic                                saturated
);

  // substep register
  logic [ssu_pkg::DT_W-1:0] time_step;

  // front to back word queue
  logic          mid_push;
  logic          mid_full;
  logic          mid_pop;
  logic          mid_empty;
  ssu_pkg::mid_t mid_in;
  ssu_pkg::mid_t mid_out;

  // result queue
  logic          out_push;
  logic          out_full;
  logic          out_pop;
  logic          out_empty;
  ssu_pkg::out_t out_in;
  ssu_pkg::out_t out_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= ssu_pkg::DT_RESET;
    end else if (time_step_we) begin
      time_step <= time_step_wdata;
    end
  end

  // history lookup, fill decision and history write back
  ssu_front #(
    .ELEMENTS (ELEMENTS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .dt              (time_step),
    .push            (push),
    .element_index   (element_index),
    .current_value   (current_value),
    .convective_rate (convective_rate),
    .diffusive_rate  (diffusive_rate),
    .restart         (restart),
    .full            (full),
    .mid_push        (mid_push),
    .mid_data        (mid_in),
    .mid_full        (mid_full)
  );

  // decouples the front from a stalled back end
  ssu_fifo #(
    .WIDTH ($bits(ssu_pkg::mid_t)),
    .DEPTH (ssu_pkg::QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty)
  );

  // arithmetic of the update
  ssu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .dt        (time_step),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_data  (mid_out),
    .out_full  (out_full),
    .out_pop   (out_pop),
    .out_push  (out_push),
    .out_data  (out_in)
  );

  // finished words wait here for the receiver
  ssu_fifo #(
    .WIDTH ($bits(ssu_pkg::out_t)),
    .DEPTH (ssu_pkg::QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_in),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_head),
    .empty (out_empty)
  );

  assign empty        = rst | out_empty;
  assign out_pop      = pop & ~empty;
  assign result_index = out_head.idx;
  assign next_value   = out_head.value;
  assign saturated    = out_head.sat;

endmodule
